@@ rtl/rs485b_pkg.sv @@
// Shared constants, types and helpers of the RS485 half-duplex buffer.
package rs485b_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 3;
  localparam int DELAY_W    = 16;
  localparam int TIMEOUT_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_W      = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_TRANSMIT_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;

  localparam logic [CMD_W-1:0] CMD_LINE_RX  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TX_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TX_DONE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOST_WR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HOST_RD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd6;

  typedef struct packed {
    logic accept;
    logic load;
    logic reload;
    logic rx_push;
    logic rx_pop;
    logic tx_push;
    logic tx_pop;
    logic dir_clear;
    logic tick;
    logic check;
  } dp_cmd_t;

  typedef struct packed {
    logic rx_full;
    logic rx_empty;
    logic tx_full;
    logic tx_empty;
    logic delay_zero;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

@@ rtl/rs485b_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rs485b_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rs485b_ctrl.sv @@
// Controller: input and output handshake and decode of each command.
module rs485b_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rs485b_pkg::CMD_W-1:0]    s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  rs485b_pkg::dp_stat_t            stat,
  output rs485b_pkg::dp_cmd_t             cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                         state;
  logic                         state_next;
  logic                         out_valid;
  logic                         out_valid_next;
  logic [rs485b_pkg::CMD_W-1:0] cmd_q;
  logic                         go;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // The item executes once the output register is free or being emptied.
  assign go = (state == ST_EXEC) && (!out_valid || m_tready);

  always_comb begin
    cmd        = '0;
    cmd.accept = s_tvalid && s_tready;
    cmd.load   = go;
    if (go) begin
      unique case (cmd_q)
        rs485b_pkg::CMD_LINE_RX: begin
          cmd.reload  = 1'b1;
          cmd.rx_push = !stat.rx_full;
        end
        rs485b_pkg::CMD_TX_FREE: cmd.tx_pop    = stat.delay_zero && !stat.tx_empty;
        rs485b_pkg::CMD_TX_DONE: cmd.dir_clear = 1'b1;
        rs485b_pkg::CMD_HOST_WR: cmd.tx_push   = !stat.tx_full;
        rs485b_pkg::CMD_HOST_RD: cmd.rx_pop    = !stat.rx_empty;
        rs485b_pkg::CMD_TICK:    cmd.tick      = 1'b1;
        rs485b_pkg::CMD_CHECK:   cmd.check     = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.accept) state_next = ST_EXEC;
      ST_EXEC: if (go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (go) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    if (cmd.accept) begin
      cmd_q <= s_tuser;
    end
  end

endmodule

@@ rtl/rs485b_dp.sv @@
// Datapath: both rings, timers, direction, configuration and output register.
module rs485b_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rs485b_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rs485b_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [rs485b_pkg::BYTE_W-1:0]       s_tdata,
  output logic [rs485b_pkg::OUT_W-1:0]        m_tdata,
  input  rs485b_pkg::dp_cmd_t                 cmd,
  output rs485b_pkg::dp_stat_t                stat
);

  logic [rs485b_pkg::PTR_W-1:0]     rx_head, rx_tail, tx_head, tx_tail;
  logic [rs485b_pkg::DELAY_W-1:0]   delay_timer;
  logic [rs485b_pkg::TIMEOUT_W-1:0] timeout_timer;
  logic                             timeout_flag;
  logic                             direction_send;
  logic [rs485b_pkg::DELAY_W-1:0]   transmit_delay;
  logic [rs485b_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [rs485b_pkg::BYTE_W-1:0]    data_q;
  logic [rs485b_pkg::BYTE_W-1:0]    rx_rdata, tx_rdata;
  logic                             send_next;

  // Reads are issued when the item is taken; pointers are settled by then.
  rs485b_ram #(.WIDTH(rs485b_pkg::BYTE_W), .DEPTH(rs485b_pkg::FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.rx_push),
    .waddr (rx_head),
    .wdata (data_q),
    .re    (cmd.accept),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  rs485b_ram #(.WIDTH(rs485b_pkg::BYTE_W), .DEPTH(rs485b_pkg::FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (cmd.tx_push),
    .waddr (tx_head),
    .wdata (data_q),
    .re    (cmd.accept),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  assign stat.rx_full    = (rs485b_pkg::next_slot(rx_head) == rx_tail);
  assign stat.rx_empty   = (rx_head == rx_tail);
  assign stat.tx_full    = (rs485b_pkg::next_slot(tx_head) == tx_tail);
  assign stat.tx_empty   = (tx_head == tx_tail);
  assign stat.delay_zero = (delay_timer == '0);

  always_comb begin
    send_next = direction_send;
    if (cmd.tx_pop) begin
      send_next = 1'b1;
    end else if (cmd.dir_clear) begin
      send_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head        <= '0;
      rx_tail        <= '0;
      tx_head        <= '0;
      tx_tail        <= '0;
      delay_timer    <= '0;
      timeout_timer  <= '0;
      timeout_flag   <= 1'b0;
      direction_send <= 1'b0;
      transmit_delay <= '0;
      timeout_ticks  <= rs485b_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rs485b_pkg::REG_TRANSMIT_DELAY: transmit_delay <= cfg_data;
          rs485b_pkg::REG_TIMEOUT_TICKS:
            timeout_ticks <= cfg_data[rs485b_pkg::TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.rx_push) rx_head <= rs485b_pkg::next_slot(rx_head);
      if (cmd.rx_pop)  rx_tail <= rs485b_pkg::next_slot(rx_tail);
      if (cmd.tx_push) tx_head <= rs485b_pkg::next_slot(tx_head);
      if (cmd.tx_pop)  tx_tail <= rs485b_pkg::next_slot(tx_tail);
      direction_send <= send_next;
      if (cmd.reload) begin
        timeout_timer <= timeout_ticks;
        delay_timer   <= transmit_delay;
      end else if (cmd.tick) begin
        if (delay_timer != '0) begin
          delay_timer <= delay_timer - rs485b_pkg::DELAY_W'(1);
        end
        // The flag rises only on the step from one to zero.
        if (timeout_timer != '0) begin
          timeout_timer <= timeout_timer - rs485b_pkg::TIMEOUT_W'(1);
          if (timeout_timer == rs485b_pkg::TIMEOUT_W'(1)) begin
            timeout_flag <= 1'b1;
          end
        end
      end
      if (cmd.check) begin
        timeout_flag <= 1'b0;
      end
    end
    if (cmd.accept) begin
      data_q <= s_tdata;
    end
    if (cmd.load) begin
      m_tdata <= {3'b000,
                  cmd.check && timeout_flag,
                  send_next,
                  cmd.tx_pop,
                  cmd.tx_pop ? tx_rdata : rs485b_pkg::BYTE_W'(0),
                  cmd.tx_push,
                  cmd.rx_pop,
                  cmd.rx_pop ? rx_rdata : rs485b_pkg::BYTE_W'(0)};
    end
  end

endmodule

@@ rtl/rs485_half_duplex_uart_buffer.sv @@
// Top level of the RS485 half-duplex buffer: receive ring, transmit ring and driver
// direction control. One input item carries an event code in s_tuser (line byte
// received, transmitter free, transmit complete, host write, host read, tick,
// check timeout) and a byte in s_tdata. Every input item produces exactly one
// result item on the m_ side, packed into m_tdata.
// An item is taken, then executed once both ring RAMs have returned their registered
// read data and the output register is free or being emptied; the result is then
// loaded into the output register. No new item is taken before the last executes:
// the registered RAM read sits between taking an item and updating the pointers.
// If m_tready is low, the result waits in the output register; the block still
// takes the next item, then holds it until the output register is freed.
// Reset (rst, synchronous) empties both rings, clears both timers, the timeout
// flag and the send direction, and restores the register defaults (delay 0,
// timeout 5 ticks). Ring contents are not cleared, no pass over them is needed.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module rs485_half_duplex_uart_buffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rs485b_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rs485b_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [7:0] data
  input  logic [2:0]                        s_tuser,  // [2:0] command
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] read_data, [8] read_valid, [9] write_accepted, [17:10] line_byte,
  // [18] line_valid, [19] send_mode, [20] timeout_seen, [23:21] zero
  output logic [23:0]                       m_tdata
);

  rs485b_pkg::dp_cmd_t  cmd;
  rs485b_pkg::dp_stat_t stat;

  rs485b_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rs485b_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ rtl/rs485b_check.sv @@
// Port-level checker for the RS485 half-duplex buffer, bound to the top level.
module rs485b_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One item at a time: after an item is taken the input side closes.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  // A failed host read returns a zero byte.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] || (m_tdata[7:0] == 8'd0)))
    else $error("read byte without read_valid");

  // Sending a byte always leaves the driver in send mode.
  a_send_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[19] && (m_tdata[9:8] == 2'b00))
    else $error("line byte sent without send mode");

endmodule

bind rs485_half_duplex_uart_buffer rs485b_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ test/rs485_buffer_checker.sv @@
// Checker for the RS485 buffer: watches both streams, predicts every result and compares it.
`timescale 1ns / 1ps
module rs485_buffer_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rs485b_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rs485b_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [7:0] data
  input  logic [2:0]                        s_tuser,  // [2:0] command
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] read_data, [8] read_valid, [9] write_accepted, [17:10] line_byte,
  // [18] line_valid, [19] send_mode, [20] timeout_seen, [23:21] zero
  input  logic [23:0]                       m_tdata,
  output int                                mismatch_count,
  output int                                outstanding
);
  import rs485b_pkg::*;

  typedef struct packed {
    logic [2:0] pad;
    logic       timeout_seen;
    logic       send_mode;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       write_accepted;
    logic       read_valid;
    logic [7:0] read_data;
  } buffer_result_t;

  buffer_result_t awaited_results[$];
  buffer_result_t exp_item;
  buffer_result_t got_item;

  logic [BYTE_W-1:0]    rx_ring [FIFO_DEPTH];
  logic [BYTE_W-1:0]    tx_ring [FIFO_DEPTH];
  logic [PTR_W-1:0]     rx_wr, rx_rd, tx_wr, tx_rd;
  logic [DELAY_W-1:0]   turn_cnt, delay_reg;
  logic [TIMEOUT_W-1:0] idle_cnt, idle_reg;
  logic                 idle_flag;
  logic                 driving;

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    int n;
    n = int'(p) + 1;
    if (n >= FIFO_DEPTH) n = 0;
    return PTR_W'(n);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      turn_cnt = '0;
      idle_cnt = '0;
      idle_flag = 1'b0;
      driving = 1'b0;
      delay_reg = '0;
      idle_reg = TIMEOUT_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TRANSMIT_DELAY) delay_reg = cfg_data[DELAY_W-1:0];
        else if (cfg_index == REG_TIMEOUT_TICKS) idle_reg = cfg_data[TIMEOUT_W-1:0];
      end

      if (m_tvalid && m_tready) begin
        got_item = m_tdata;
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result arrived, expected none, actual %0h", $time, m_tdata);
          mismatch_count++;
        end else begin
          exp_item = awaited_results.pop_front();
          check_field("read_data", exp_item.read_data, got_item.read_data);
          check_field("read_valid", exp_item.read_valid, got_item.read_valid);
          check_field("write_accepted", exp_item.write_accepted, got_item.write_accepted);
          check_field("line_byte", exp_item.line_byte, got_item.line_byte);
          check_field("line_valid", exp_item.line_valid, got_item.line_valid);
          check_field("send_mode", exp_item.send_mode, got_item.send_mode);
          check_field("timeout_seen", exp_item.timeout_seen, got_item.timeout_seen);
          check_field("pad", exp_item.pad, got_item.pad);
        end
      end

      if (s_tvalid && s_tready) begin
        exp_item = '0;
        case (s_tuser)
          CMD_LINE_RX: begin
            // A full ring drops the byte, yet both timers reload anyway.
            if (ring_advance(rx_wr) != rx_rd) begin
              rx_ring[rx_wr] = s_tdata;
              rx_wr = ring_advance(rx_wr);
            end
            idle_cnt = idle_reg;
            turn_cnt = delay_reg;
          end
          CMD_TX_FREE: begin
            if (turn_cnt == '0 && tx_wr != tx_rd) begin
              driving = 1'b1;
              exp_item.line_byte = tx_ring[tx_rd];
              exp_item.line_valid = 1'b1;
              tx_rd = ring_advance(tx_rd);
            end
          end
          CMD_TX_DONE: driving = 1'b0;
          CMD_HOST_WR: begin
            if (ring_advance(tx_wr) != tx_rd) begin
              tx_ring[tx_wr] = s_tdata;
              tx_wr = ring_advance(tx_wr);
              exp_item.write_accepted = 1'b1;
            end
          end
          CMD_HOST_RD: begin
            if (rx_rd != rx_wr) begin
              exp_item.read_data = rx_ring[rx_rd];
              exp_item.read_valid = 1'b1;
              rx_rd = ring_advance(rx_rd);
            end
          end
          CMD_TICK: begin
            if (turn_cnt != '0) turn_cnt = turn_cnt - DELAY_W'(1);
            // The flag rises only on the step from one to zero.
            if (idle_cnt != '0) begin
              idle_cnt = idle_cnt - TIMEOUT_W'(1);
              if (idle_cnt == '0) idle_flag = 1'b1;
            end
          end
          CMD_CHECK: begin
            exp_item.timeout_seen = idle_flag;
            idle_flag = 1'b0;
          end
          default: ;
        endcase
        exp_item.send_mode = driving;
        awaited_results.push_back(exp_item);
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ test/tb_rs485_half_duplex_uart_buffer.sv @@
// Testbench top for the RS485 half-duplex buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_rs485_half_duplex_uart_buffer;
  import rs485b_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 6;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;  // [7:0] data
  logic [2:0]            s_tuser = '0;  // [2:0] command
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [7:0] read_data, [8] read_valid, [9] write_accepted, [17:10] line_byte,
  // [18] line_valid, [19] send_mode, [20] timeout_seen, [23:21] zero
  logic [23:0]           m_tdata;

  int mismatch_count;
  int outstanding;
  int items_sent = 0;
  int cycle_count = 0;
  bit gapless = 1'b0;
  bit hold_request = 1'b0;

  rs485_half_duplex_uart_buffer dut (.*);

  rs485_buffer_checker checker_i (.*);

  initial forever #6 clk = ~clk;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk) cycle_count++;
    $display("** rs485_half_duplex_uart_buffer: FAILED **");
    $finish;
  end

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin
    int r;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(0, 15)) @(negedge clk);
        end else if (r < 94) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(0, 3)) @(negedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // tvalid still high, so the next item can follow without a gap.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [7:0] value);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (gapless || r < 65) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One short sequence: ring fills, drains, transmit handshakes, timer runs or noise.
  task automatic run_segment();
    int kind;
    int r;
    kind = $urandom_range(0, 5);
    case (kind)
      0: repeat ($urandom_range(30, 36)) send_item(CMD_LINE_RX, rand_byte());
      1: repeat ($urandom_range(30, 36)) send_item(CMD_HOST_WR, rand_byte());
      2: repeat ($urandom_range(5, 34)) send_item(CMD_HOST_RD, rand_byte());
      3: begin
        repeat ($urandom_range(4, 12)) begin
          if ($urandom_range(0, 9) < 3) send_item(CMD_TICK, rand_byte());
          send_item(CMD_TX_FREE, rand_byte());
          if ($urandom_range(0, 1) == 1) send_item(CMD_TX_DONE, rand_byte());
        end
      end
      4: begin
        send_item(CMD_LINE_RX, rand_byte());
        repeat ($urandom_range(0, 8)) send_item(CMD_TICK, rand_byte());
        send_item(CMD_CHECK, rand_byte());
      end
      default: begin
        repeat ($urandom_range(10, 30)) begin
          r = $urandom_range(0, 49);
          if (r == 0) send_item(CMD_UNUSED, rand_byte());
          else send_item(CMD_W'($urandom_range(0, 6)), rand_byte());
        end
      end
    endcase
  endtask

  initial begin
    int phase;
    int phase_start;
    bit pressure_done;
    logic [DELAY_W-1:0] delay_val;
    logic [CFG_DATA_W-1:0] timeout_val;
    pressure_done = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset register values: empty rings, the unused
    // code, a send and its completion, reads down to empty, and a timeout.
    send_item(CMD_CHECK, 8'h00);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_HOST_RD, 8'h00);
    send_item(CMD_TX_FREE, 8'hFF);
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_HOST_WR, 8'h00);
    send_item(CMD_HOST_WR, 8'hFF);
    send_item(CMD_TX_FREE, 8'h00);
    send_item(CMD_UNUSED, 8'h00);
    send_item(CMD_TX_DONE, 8'h00);
    send_item(CMD_LINE_RX, 8'hFF);
    send_item(CMD_LINE_RX, 8'h00);
    send_item(CMD_HOST_RD, 8'h00);
    send_item(CMD_HOST_RD, 8'h00);
    send_item(CMD_HOST_RD, 8'h00);
    repeat (5) send_item(CMD_TICK, 8'h00);
    send_item(CMD_CHECK, 8'h00);
    send_item(CMD_CHECK, 8'h00);
    send_item(CMD_TX_FREE, 8'h00);
    send_item(CMD_TX_DONE, 8'h00);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin delay_val = 16'd0;     timeout_val = 16'd0;      end
        1: begin delay_val = 16'hFFFF;  timeout_val = 16'hFFFF;   end
        2: begin delay_val = 16'd1;     timeout_val = {8'($urandom), 8'd1}; end
        3: begin delay_val = 16'd3;     timeout_val = {8'($urandom), 8'd2}; end
        4: begin
          delay_val = DELAY_W'($urandom_range(0, 6));
          timeout_val = {8'($urandom), 8'($urandom_range(0, 12))};
        end
        default: begin delay_val = 16'd0; timeout_val = 16'd5; end
      endcase
      write_reg(REG_TRANSMIT_DELAY, delay_val);
      write_reg(REG_TIMEOUT_TICKS, timeout_val);

      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if (phase == 2 && !pressure_done && items_sent - phase_start > 40) begin
          // Keep offering items back to back while the receiver holds off.
          hold_request = 1'b1;
          gapless = 1'b1;
          repeat (40) send_item(CMD_W'($urandom_range(0, 6)), rand_byte());
          gapless = 1'b0;
          pressure_done = 1'b1;
          wait_idle();
        end
        run_segment();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("** rs485_half_duplex_uart_buffer: PASSED **");
    else
      $display("** rs485_half_duplex_uart_buffer: FAILED **");
    $finish;
  end

endmodule
